### rtl/core/sdfp_pkg.sv
// shared constants and types of the sample delta frame packer
`default_nettype none

package sdfp_pkg;

    localparam int DELTA_LIMIT  = 32;
    localparam int STORE_DEPTH  = 32;
    localparam int STORE_AW     = 5;
    localparam int CNT_W        = 6;
    localparam int SAMPLE_W     = 24;
    localparam int DELTA_W      = 16;
    localparam int SEQ_W        = 8;
    localparam int OP_W         = 2;

    // frame capacity, bounded by the delta store
    localparam int CAPACITY_I   = (DELTA_LIMIT > STORE_DEPTH) ? STORE_DEPTH : DELTA_LIMIT;
    localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(CAPACITY_I);

    // operation codes
    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
    localparam logic [OP_W-1:0] OP_FLUSH  = 2'd1;
    localparam logic [OP_W-1:0] OP_RESET  = 2'd2;

    typedef struct packed {
        logic                en;
        logic [STORE_AW-1:0] addr;
        logic [DELTA_W-1:0]  data;
    } sdfp_ram_wr_t;

    typedef struct packed {
        logic                en;
        logic [STORE_AW-1:0] addr;
    } sdfp_ram_rd_t;

    typedef struct packed {
        logic [SEQ_W-1:0]         seq;
        logic [SAMPLE_W-1:0]      first_sample;
        logic [SAMPLE_W-1:0]      frame_rate;
        logic [CNT_W-1:0]         delta_count;
        logic [STORE_AW-1:0]      delta_index;
        logic signed [DELTA_W-1:0] delta_value;
        logic                     delta_valid;
        logic                     last;
    } sdfp_item_t;

endpackage

`default_nettype wire

### rtl/core/sdfp_delta_ram.sv
// delta store: one write port, one registered read port
`default_nettype none

module sdfp_delta_ram (
    input  wire logic                          aclk,
    input  wire sdfp_pkg::sdfp_ram_wr_t        wr,
    input  wire sdfp_pkg::sdfp_ram_rd_t        rd,
    output logic [sdfp_pkg::DELTA_W-1:0]       rd_data
);

    logic [sdfp_pkg::DELTA_W-1:0] mem [sdfp_pkg::STORE_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rd_data <= mem[rd.addr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/sdfp_framer.sv
// frame state, delta append and frame readout sequencer with output register
`default_nettype none

module sdfp_framer (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [sdfp_pkg::OP_W-1:0]         in_op,
    input  wire logic [sdfp_pkg::SAMPLE_W-1:0]     in_sample,
    input  wire logic [sdfp_pkg::SAMPLE_W-1:0]     in_rate,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output sdfp_pkg::sdfp_item_t                   out_item,
    output sdfp_pkg::sdfp_ram_wr_t                 ram_wr,
    output sdfp_pkg::sdfp_ram_rd_t                 ram_rd,
    input  wire logic [sdfp_pkg::DELTA_W-1:0]      ram_rd_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic                            state_reg, state_next;
    logic                            open_reg, open_next;
    logic [sdfp_pkg::SAMPLE_W-1:0]   prev_reg, prev_next;
    logic [sdfp_pkg::SAMPLE_W-1:0]   head_reg, head_next;
    logic [sdfp_pkg::SAMPLE_W-1:0]   rate_reg, rate_next;
    logic [sdfp_pkg::CNT_W-1:0]      fill_reg, fill_next;
    logic [sdfp_pkg::SEQ_W-1:0]      seq_reg, seq_next;

    // snapshot of the frame being read out
    logic [sdfp_pkg::SEQ_W-1:0]      snap_seq_reg, snap_seq_next;
    logic [sdfp_pkg::SAMPLE_W-1:0]   snap_head_reg, snap_head_next;
    logic [sdfp_pkg::SAMPLE_W-1:0]   snap_rate_reg, snap_rate_next;
    logic [sdfp_pkg::CNT_W-1:0]      snap_n_reg, snap_n_next;
    logic [sdfp_pkg::CNT_W-1:0]      rd_cnt_reg, rd_cnt_next;
    logic [sdfp_pkg::STORE_AW-1:0]   ld_idx_reg, ld_idx_next;
    logic                            rd_pend_reg, rd_pend_next;

    logic                            out_valid_reg, out_valid_next;
    sdfp_pkg::sdfp_item_t            out_item_reg, out_item_next;

    logic                            accept;
    logic [sdfp_pkg::SAMPLE_W:0]     diff;
    logic                            in_range;
    logic                            full;
    logic                            out_free;
    logic                            load;
    logic                            load_last;
    logic                            empty_load;
    logic                            issue;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign diff      = {1'b0, in_sample} - {1'b0, prev_reg};
    assign in_range  = (diff[sdfp_pkg::SAMPLE_W:sdfp_pkg::DELTA_W-1]
                        == {(sdfp_pkg::SAMPLE_W-sdfp_pkg::DELTA_W+2){diff[sdfp_pkg::DELTA_W-1]}});
    assign full      = (fill_reg >= sdfp_pkg::CAPACITY);

    assign out_free   = !out_valid_reg || out_ready;
    assign empty_load = (state_reg == ST_EMIT) && (snap_n_reg == '0) && out_free;
    assign load       = (state_reg == ST_EMIT) && (snap_n_reg != '0) && rd_pend_reg && out_free;
    assign load_last  = load
                        && ((sdfp_pkg::CNT_W'(ld_idx_reg) + sdfp_pkg::CNT_W'(1)) == snap_n_reg);
    assign issue      = (state_reg == ST_EMIT) && (rd_cnt_reg < snap_n_reg)
                        && (!rd_pend_reg || load);

    assign ram_rd.en   = issue;
    assign ram_rd.addr = rd_cnt_reg[sdfp_pkg::STORE_AW-1:0];

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb begin
        state_next     = state_reg;
        open_next      = open_reg;
        prev_next      = prev_reg;
        head_next      = head_reg;
        rate_next      = rate_reg;
        fill_next      = fill_reg;
        seq_next       = seq_reg;
        snap_seq_next  = snap_seq_reg;
        snap_head_next = snap_head_reg;
        snap_rate_next = snap_rate_reg;
        snap_n_next    = snap_n_reg;
        rd_cnt_next    = rd_cnt_reg;
        ld_idx_next    = ld_idx_reg;
        rd_pend_next   = rd_pend_reg;
        ram_wr.en      = 1'b0;
        ram_wr.addr    = fill_reg[sdfp_pkg::STORE_AW-1:0];
        ram_wr.data    = diff[sdfp_pkg::DELTA_W-1:0];

        if (accept) begin
            // snapshot used whenever this word closes a frame
            snap_seq_next  = seq_reg;
            snap_head_next = head_reg;
            snap_rate_next = rate_reg;
            snap_n_next    = fill_reg;
            rd_cnt_next    = '0;
            rd_pend_next   = 1'b0;
            unique case (in_op)
                sdfp_pkg::OP_RESET: begin
                    open_next = 1'b0;
                    prev_next = '0;
                    head_next = '0;
                    rate_next = '0;
                    fill_next = '0;
                    seq_next  = '0;
                end
                sdfp_pkg::OP_FLUSH: begin
                    if (open_reg) begin
                        state_next = ST_EMIT;
                        seq_next   = seq_reg + 1'b1;
                    end
                    open_next = 1'b0;
                    prev_next = '0;
                    head_next = '0;
                    rate_next = '0;
                    fill_next = '0;
                end
                sdfp_pkg::OP_SAMPLE: begin
                    if (!open_reg || !in_range || full) begin
                        if (open_reg) begin
                            state_next = ST_EMIT;
                            seq_next   = seq_reg + 1'b1;
                        end
                        open_next = 1'b1;
                        prev_next = in_sample;
                        head_next = in_sample;
                        rate_next = in_rate;
                        fill_next = '0;
                    end else begin
                        ram_wr.en = 1'b1;
                        fill_next = fill_reg + 1'b1;
                        prev_next = in_sample;
                        rate_next = in_rate;
                    end
                end
                default: begin
                end
            endcase
        end

        if (issue) begin
            rd_cnt_next  = rd_cnt_reg + 1'b1;
            ld_idx_next  = rd_cnt_reg[sdfp_pkg::STORE_AW-1:0];
            rd_pend_next = 1'b1;
        end else if (load) begin
            rd_pend_next = 1'b0;
        end

        if (empty_load || load_last) begin
            state_next = ST_IDLE;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (empty_load || load) begin
            out_valid_next             = 1'b1;
            out_item_next.seq          = snap_seq_reg;
            out_item_next.first_sample = snap_head_reg;
            out_item_next.frame_rate   = snap_rate_reg;
            out_item_next.delta_count  = snap_n_reg;
            out_item_next.delta_index  = load ? ld_idx_reg : '0;
            out_item_next.delta_value  = load ? $signed(ram_rd_data) : '0;
            out_item_next.delta_valid  = load;
            out_item_next.last         = empty_load || load_last;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            open_reg      <= 1'b0;
            prev_reg      <= '0;
            head_reg      <= '0;
            rate_reg      <= '0;
            fill_reg      <= '0;
            seq_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            open_reg      <= open_next;
            prev_reg      <= prev_next;
            head_reg      <= head_next;
            rate_reg      <= rate_next;
            fill_reg      <= fill_next;
            seq_reg       <= seq_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        snap_seq_reg  <= snap_seq_next;
        snap_head_reg <= snap_head_next;
        snap_rate_reg <= snap_rate_next;
        snap_n_reg    <= snap_n_next;
        rd_cnt_reg    <= rd_cnt_next;
        ld_idx_reg    <= ld_idx_next;
        out_item_reg  <= out_item_next;
    end

endmodule

`default_nettype wire

### rtl/core/sample_delta_frame_packer.sv
// top level of the sample delta frame packer
// usage:
//   s_ channel takes one word per command: s_tuser carries the operation
//   (sample, flush, reset of frame and sequence), s_tdata the sample and rate
//   m_ channel gives one word per delta of an emitted frame, or a single
//   word with m_tuser low for a frame without deltas; m_tlast marks the
//   final word of each frame
// timing:
//   a word that only appends a delta or opens a frame keeps s_tready high
//   a word that closes a frame holds s_tready low while the frame is read
//   from the delta store; each result passes the store read register and
//   the output register (a frame without deltas only the output register);
//   results follow at one per cycle while m_ is not stalled, set by the
//   single read port of the delta store
// reset:
//   aresetn clears the frame and sequence state; the delta store is not
//   cleared, entries are always written before they are read
// back pressure:
//   a stalled m_ side holds the output register and pauses the store
//   readout; s_tready stays high between frames even while a result waits
`default_nettype none

module sample_delta_frame_packer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // sample [23:0], rate [47:24]
    input  wire logic [1:0]  s_tuser,   // operation [1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [87:0]      m_tdata,   // sequence_res [7:0], first_sample [31:8],
                                        // frame_rate [55:32], delta_count [61:56],
                                        // delta_index [66:62], delta_value [82:67],
                                        // zero [87:83]
    output logic [0:0]       m_tuser,   // delta_valid [0]
    output logic             m_tlast
);

    sdfp_pkg::sdfp_ram_wr_t          ram_wr;
    sdfp_pkg::sdfp_ram_rd_t          ram_rd;
    logic [sdfp_pkg::DELTA_W-1:0]    ram_rd_data;
    sdfp_pkg::sdfp_item_t            item;

    // frame control and readout sequencer
    sdfp_framer u_framer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_op       (s_tuser),
        .in_sample   (s_tdata[23:0]),
        .in_rate     (s_tdata[47:24]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_item    (item),
        .ram_wr      (ram_wr),
        .ram_rd      (ram_rd),
        .ram_rd_data (ram_rd_data)
    );

    // delta store, written on append and read during frame readout
    sdfp_delta_ram u_ram (
        .aclk    (aclk),
        .wr      (ram_wr),
        .rd      (ram_rd),
        .rd_data (ram_rd_data)
    );

    // pack result fields from the lowest bit up
    assign m_tdata = {5'b0,
                      item.delta_value,
                      item.delta_index,
                      item.delta_count,
                      item.frame_rate,
                      item.first_sample,
                      item.seq};
    assign m_tuser = item.delta_valid;
    assign m_tlast = item.last;

endmodule

`default_nettype wire

### rtl/core/sdfp_checker.sv
// port-level checks of the sample delta frame packer and their binding
`default_nettype none

module sdfp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [87:0] m_tdata,
    input wire logic [0:0]  m_tuser,
    input wire logic        m_tlast
);

    // no result word survives a reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word valid right after reset");

    // stalled word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result word changed");

    // frame without deltas is a single word with zero count
    a_empty_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast && (m_tdata[61:56] == 6'd0))
        else $error("frame without deltas malformed");

    // last marks the final delta of the frame
    a_last_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |->
            (m_tlast == (({1'b0, m_tdata[66:62]} + 6'd1) == m_tdata[61:56])))
        else $error("frame end mark at wrong delta");

endmodule

bind sample_delta_frame_packer sdfp_checker u_sdfp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
